FILE: rtl/fcwl_pkg.sv
// Shared constants, types and a helper function for the frame change warning level block.
package fcwl_pkg;

	localparam int THUMB_WIDTH    = 48;
	localparam int THUMB_ROWS_MAX = 64;
	localparam int STORE_DEPTH    = THUMB_WIDTH * THUMB_ROWS_MAX;
	localparam int IDX_W          = $clog2(STORE_DEPTH);
	localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W          = CNT_W + 8;
	localparam int Q16_W          = 17;
	localparam logic [15:0] ALPHA_RESET = 16'd7701;
	localparam logic [16:0] Q16_ONE     = 17'd65536;

	// Frame-close word handed from the pixel path to the frame-end unit
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             matched;
	} frame_info_t;

	// Integer luma floor((11b + 59g + 30r) / 100); the divide is a reciprocal multiply
	function automatic logic [7:0] luma_of(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		logic [14:0] s;
		logic [31:0] p;
		logic [7:0]  qt;
		logic [14:0] rem;
		s   = 15'(11 * b) + 15'(59 * g) + 15'(30 * r);
		p   = 32'(s) * 32'd41944;
		qt  = p[29:22];
		rem = s - 15'(qt) * 15'd100;
		if (rem >= 15'd100)
			qt = qt + 8'd1;
		return qt;
	endfunction

endpackage

FILE: rtl/frame_change_warning_level.sv
// Top level of the frame change warning level block: handshakes, config and output register.
// Pixels: one word a cycle while in_stall is low; each luma is written back to the store
// in the cycle after acceptance. Frame close: the bit-serial divide runs only with a matched
// history; input stalls until the result word leaves.
// Reset: asynchronous active low; clears history, count, level and alpha
// (to 7701); the luma store itself is not cleared.
module frame_change_warning_level (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        last_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] change_amount,
	output logic [16:0] warning_level,
	output logic [7:0]  overlay_red,
	output logic [7:0]  overlay_green,
	output logic [7:0]  overlay_blue,
	output logic        history_matched
);

	logic                  in_take;
	logic                  frame_done;
	fcwl_pkg::frame_info_t frame_info;
	logic                  busy;
	logic                  done;
	logic                  close_q;
	logic [15:0]           alpha_q;
	logic [16:0]           chg;
	logic [16:0]           lvl;
	logic [7:0]            r;
	logic [7:0]            g;
	logic [7:0]            b;
	logic                  mat;

	// Hold input from the last pixel until the result word leaves
	assign in_stall  = close_q || busy || done || out_valid;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= 1'b0;
			alpha_q <= fcwl_pkg::ALPHA_RESET;
		end else begin
			if (in_take && last_pixel)
				close_q <= 1'b1;
			else if (frame_done)
				close_q <= 1'b0;
			if (cfg_valid)
				alpha_q <= cfg_data;
		end
	end

	fcwl_pixel u_pixel (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_take),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.last_pixel (last_pixel),
		.frame_done (frame_done),
		.frame_info (frame_info)
	);

	fcwl_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (frame_done),
		.info      (frame_info),
		.alpha_cfg (alpha_q),
		.busy      (busy),
		.done      (done),
		.change_o  (chg),
		.level_o   (lvl),
		.r_o       (r),
		.g_o       (g),
		.b_o       (b),
		.matched_o (mat)
	);

	// Output register: load on done, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (done)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			change_amount   <= chg;
			warning_level   <= lvl;
			overlay_red     <= r;
			overlay_green   <= g;
			overlay_blue    <= b;
			history_matched <= mat;
		end
	end

endmodule

FILE: rtl/fcwl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module fcwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/fcwl_pixel.sv
// Per-pixel path: luma, history compare through the store, difference sum and count.
module fcwl_pixel (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_take,
	input  logic [7:0]             blue,
	input  logic [7:0]             green,
	input  logic [7:0]             red,
	input  logic                   last_pixel,
	output logic                   frame_done,
	output fcwl_pkg::frame_info_t  frame_info
);

	logic [fcwl_pkg::IDX_W-1:0] idx_q;
	logic [fcwl_pkg::CNT_W-1:0] cnt_q;
	logic [fcwl_pkg::CNT_W-1:0] stored_cnt_q;
	logic                       hist_q;
	logic [fcwl_pkg::SUM_W-1:0] sum_q;
	logic                       full_q;

	// Stage 1 registers: luma and flags while the store read is in flight
	logic       v_s1;
	logic       wr_s1;
	logic       last_s1;
	logic [7:0] luma_s1;
	logic [7:0] old;
	logic [7:0] ad;
	logic [fcwl_pkg::SUM_W-1:0] sum_nx;
	logic [fcwl_pkg::CNT_W-1:0] cnt_nx;

	// Store entry read now, written back in the next cycle at the same index
	logic [fcwl_pkg::IDX_W-1:0] widx_s1;

	fcwl_ram #(.WIDTH(8), .DEPTH(fcwl_pkg::STORE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (v_s1 && wr_s1),
		.waddr (widx_s1),
		.wdata (luma_s1),
		.raddr (idx_q),
		.rdata (old)
	);

	// Issue: advance index, note whether this pixel fits the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			idx_q  <= '0;
			full_q <= 1'b0;
		end else begin
			v_s1 <= in_take;
			if (in_take) begin
				if (last_pixel) begin
					idx_q  <= '0;
					full_q <= 1'b0;
				end else if (!full_q) begin
					if (idx_q == fcwl_pkg::IDX_W'(fcwl_pkg::STORE_DEPTH - 1))
						full_q <= 1'b1;
					else
						idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			luma_s1 <= fcwl_pkg::luma_of(blue, green, red);
			wr_s1   <= !full_q;
			last_s1 <= last_pixel;
			widx_s1 <= idx_q;
		end
	end

	// Accumulate the absolute difference and the count
	always_comb begin
		ad     = (luma_s1 > old) ? luma_s1 - old : old - luma_s1;
		sum_nx = wr_s1 ? sum_q + fcwl_pkg::SUM_W'(ad) : sum_q;
		cnt_nx = wr_s1 ? cnt_q + 1'b1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			cnt_q        <= '0;
			stored_cnt_q <= '0;
			hist_q       <= 1'b0;
			frame_done   <= 1'b0;
			frame_info   <= '0;
		end else begin
			frame_done <= v_s1 && last_s1;
			if (v_s1) begin
				if (last_s1) begin
					frame_info.sum     <= sum_nx;
					frame_info.count   <= cnt_nx;
					frame_info.matched <= hist_q && cnt_nx == stored_cnt_q
						&& cnt_nx != '0;
					sum_q        <= '0;
					cnt_q        <= '0;
					stored_cnt_q <= cnt_nx;
					hist_q       <= 1'b1;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

endmodule

FILE: rtl/fcwl_frame.sv
// Frame-end unit: serial divide for the change, level smoothing and HSV overlay colour.
module fcwl_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  fcwl_pkg::frame_info_t info,
	input  logic [15:0]           alpha_cfg,
	output logic                  busy,
	output logic                  done,
	output logic [16:0]           change_o,
	output logic [16:0]           level_o,
	output logic [7:0]            r_o,
	output logic [7:0]            g_o,
	output logic [7:0]            b_o,
	output logic                  matched_o
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_LVL  = 3'd3;
	localparam logic [2:0] ST_COL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_HSV  = 3'd6;
	localparam int NUM_W = fcwl_pkg::SUM_W + 17;
	localparam int DEN_W = fcwl_pkg::CNT_W + 8;

	logic [2:0]        st_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W:0]    rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [5:0]        bit_q;
	logic [NUM_W-1:0]  quo_q;
	logic [16:0]       chg_q;
	logic [16:0]       lvl_q;
	logic              mat_q;
	logic signed [34:0] prod_q;
	logic [17:0]       xq_q;
	logic [17:0]       xt_q;
	logic [15:0]       alpha;
	logic [DEN_W:0]    rsh;
	logic signed [17:0] diff;
	logic [34:0]       mag;
	logic [18:0]       stepm;
	logic signed [19:0] lv;
	logic [17:0]       pos;
	logic [15:0]       frac;
	logic [16:0]       gq;
	logic [16:0]       gt;
	logic [7:0]        qb;
	logic [7:0]        tb;
	logic [7:0]        vb;
	logic [7:0]        pb;

	// round(255*0.92*(1 - 0.82*g/65536)) = floor((19259392000 - 240465g) / (2^17 * 625));
	// first part: numerator shifted down by 2^17
	function automatic logic [17:0] chan_x(input logic [16:0] g);
		logic [34:0] n;
		n = 35'd19259392000 - 35'(g) * 35'd240465;
		return n[34:17];
	endfunction

	// Second part: divide by 625 as a reciprocal multiply, exact for x below 2^18
	function automatic logic [7:0] chan_k(input logic [17:0] x);
		logic [35:0] p;
		p = 36'(x) * 36'd214749;
		return p[34:27];
	endfunction

	assign alpha = (alpha_cfg == '0) ? fcwl_pkg::ALPHA_RESET : alpha_cfg;
	assign busy  = st_q != ST_IDLE;
	assign rsh   = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign diff  = $signed({1'b0, fcwl_pkg::Q16_ONE - chg_q}) - $signed({1'b0, lvl_q});
	assign mag   = prod_q[34] ? 35'(-prod_q) : 35'(prod_q);
	assign stepm = 19'((mag + 35'd32768) >> 16);
	assign lv    = prod_q[34] ? $signed({3'b0, lvl_q}) - $signed({1'b0, stepm})
		: $signed({3'b0, lvl_q}) + $signed({1'b0, stepm});
	assign pos   = {fcwl_pkg::Q16_ONE - lvl_q, 1'b0};
	assign frac  = pos[15:0];
	assign gq    = {1'b0, frac};
	assign gt    = fcwl_pkg::Q16_ONE - gq;
	assign qb    = chan_k(xq_q);
	assign tb    = chan_k(xt_q);
	assign vb    = chan_k(chan_x(17'd0));
	assign pb    = chan_k(chan_x(fcwl_pkg::Q16_ONE));

	// Sequence the frame-end work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			lvl_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) begin
					num_q <= NUM_W'({info.sum, 16'd0}) + NUM_W'((DEN_W'(info.count) * 8'd255) >> 1);
					den_q <= DEN_W'(info.count) * 8'd255;
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= 6'(NUM_W);
					mat_q <= info.matched;
					st_q  <= info.matched ? ST_DIV : ST_MUL;
					chg_q <= fcwl_pkg::Q16_ONE;
				end
				ST_DIV: begin
					// One quotient bit a cycle
					num_q <= num_q << 1;
					if (rsh >= {1'b0, den_q}) begin
						rem_q <= rsh - {1'b0, den_q};
						quo_q <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[NUM_W-2:0], 1'b0};
					end
					bit_q <= bit_q - 1'b1;
					if (bit_q == 6'd1)
						st_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mat_q)
						chg_q <= (quo_q > NUM_W'(fcwl_pkg::Q16_ONE)) ? fcwl_pkg::Q16_ONE
							: quo_q[16:0];
					st_q <= ST_LVL;
				end
				ST_LVL: begin
					prod_q <= 35'(diff) * $signed({1'b0, alpha});
					st_q   <= ST_COL;
				end
				ST_COL: begin
					if (lv < 0)
						lvl_q <= '0;
					else if (lv > 20'sd65536)
						lvl_q <= fcwl_pkg::Q16_ONE;
					else
						lvl_q <= lv[16:0];
					st_q <= ST_HSV;
				end
				ST_HSV: begin
					// Hold the scaled numerators of the two varying channels
					xq_q <= chan_x(gq);
					xt_q <= chan_x(gt);
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					unique case (pos[17:16])
						2'd0:    begin r_o <= vb; g_o <= tb; b_o <= pb; end
						2'd1:    begin r_o <= qb; g_o <= vb; b_o <= pb; end
						default: begin r_o <= pb; g_o <= vb; b_o <= tb; end
					endcase
					change_o  <= chg_q;
					level_o   <= lvl_q;
					matched_o <= mat_q;
					done      <= 1'b1;
					st_q      <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: test/fcwl_checker.sv
// Checker for frame_change_warning_level: watches the channels, predicts each frame result and compares.
module fcwl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        last_pixel,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [16:0] change_amount,
	input  logic [16:0] warning_level,
	input  logic [7:0]  overlay_red,
	input  logic [7:0]  overlay_green,
	input  logic [7:0]  overlay_blue,
	input  logic        history_matched,
	output int          pending,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [16:0] change;
		logic [16:0] level;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        matched;
	} frame_result_t;

	// Model state of the block
	logic [7:0]    luma_store [fcwl_pkg::STORE_DEPTH];
	logic          have_history;
	int unsigned   prev_count;
	int unsigned   pix_pos;
	longint        abs_sum;
	longint        level_q16;
	logic [15:0]   alpha_q16;
	frame_result_t frame_results [$];

	assign pending = frame_results.size();

	// Scale one overlay channel: 255 * 0.92 * (1 - 0.82 * g), rounded half up
	function automatic logic [7:0] shade_byte(input longint g);
		longint m;
		m = 64'd6553600 - 64'd82 * g;
		return 8'((64'd23460 * m + 64'd327680000) / 64'd655360000);
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	// Close a frame: work out change, smoothed level and overlay colour
	function automatic frame_result_t close_frame();
		frame_result_t res;
		longint change, den, diff, prod, step, lv, pos, frac, wgt;
		logic   match;
		match  = have_history && pix_pos == prev_count && pix_pos != 0;
		change = fcwl_pkg::Q16_ONE;
		if (match) begin
			den    = longint'(pix_pos) * 255;
			change = (abs_sum * 65536 + den / 2) / den;
			if (change > fcwl_pkg::Q16_ONE)
				change = fcwl_pkg::Q16_ONE;
		end
		wgt  = (alpha_q16 == 0) ? fcwl_pkg::ALPHA_RESET : alpha_q16;
		diff = (fcwl_pkg::Q16_ONE - change) - level_q16;
		prod = diff * wgt;
		if (prod >= 0)
			step = (prod + 32768) >>> 16;
		else
			step = -((-prod + 32768) >>> 16);
		lv = level_q16 + step;
		if (lv < 0)
			lv = 0;
		if (lv > fcwl_pkg::Q16_ONE)
			lv = fcwl_pkg::Q16_ONE;
		level_q16 = lv;
		pos  = 2 * (fcwl_pkg::Q16_ONE - lv);
		frac = pos & 64'hFFFF;
		res.change  = 17'(change);
		res.level   = 17'(lv);
		res.matched = match;
		case (pos >> 16)
			0: begin
				res.red = shade_byte(0); res.green = shade_byte(fcwl_pkg::Q16_ONE - frac);
				res.blue = shade_byte(fcwl_pkg::Q16_ONE);
			end
			1: begin
				res.red = shade_byte(frac); res.green = shade_byte(0);
				res.blue = shade_byte(fcwl_pkg::Q16_ONE);
			end
			default: begin
				res.red = shade_byte(fcwl_pkg::Q16_ONE); res.green = shade_byte(0);
				res.blue = shade_byte(fcwl_pkg::Q16_ONE - frac);
			end
		endcase
		have_history = 1'b1;
		prev_count   = pix_pos;
		pix_pos      = 0;
		abs_sum      = 0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned   luma;
		frame_result_t want;
		if (!arst_n) begin
			have_history = 1'b0;
			prev_count   = 0;
			pix_pos      = 0;
			abs_sum      = 0;
			level_q16    = 0;
			alpha_q16    = fcwl_pkg::ALPHA_RESET;
			failures     = 0;
			frame_results.delete();
			for (int i = 0; i < fcwl_pkg::STORE_DEPTH; i++)
				luma_store[i] = 8'd0;
		end else begin
			// Check a result word against the oldest prediction
			if (out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					$display("%0t: result word with no frame pending", $realtime);
					failures++;
				end else begin
					want = frame_results.pop_front();
					if (change_amount != want.change)
						report("change_amount", change_amount, want.change);
					if (warning_level != want.level)
						report("warning_level", warning_level, want.level);
					if (overlay_red != want.red)
						report("overlay_red", overlay_red, want.red);
					if (overlay_green != want.green)
						report("overlay_green", overlay_green, want.green);
					if (overlay_blue != want.blue)
						report("overlay_blue", overlay_blue, want.blue);
					if (history_matched != want.matched)
						report("history_matched", history_matched, want.matched);
				end
			end
			// Take a register write
			if (cfg_valid && cfg_ready)
				alpha_q16 = cfg_data;
			// Advance the pixel path
			if (in_valid && !in_stall) begin
				luma = (11 * blue + 59 * green + 30 * red) / 100;
				if (pix_pos < fcwl_pkg::STORE_DEPTH) begin
					abs_sum += (luma > luma_store[pix_pos]) ? luma - luma_store[pix_pos]
						: luma_store[pix_pos] - luma;
					luma_store[pix_pos] = 8'(luma);
					pix_pos++;
				end
				if (last_pixel)
					frame_results.push_back(close_frame());
			end
		end
	end

endmodule

FILE: test/tb.sv
// Testbench top for frame_change_warning_level: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 60;
	localparam int LIMIT   = 1500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  blue = '0, green = '0, red = '0;
	logic        last_pixel = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [16:0] change_amount, warning_level;
	logic [7:0]  overlay_red, overlay_green, overlay_blue;
	logic        history_matched;
	int          pending, failures;
	int          cycles = 0;
	int          pixels_sent = 0;
	bit          calm = 1'b0;
	int          hold_cnt = 0;
	int unsigned frame_len = 16;
	logic [7:0]  last_b [fcwl_pkg::STORE_DEPTH];
	logic [7:0]  last_g [fcwl_pkg::STORE_DEPTH];
	logic [7:0]  last_r [fcwl_pkg::STORE_DEPTH];

	frame_change_warning_level dut (.*);
	fcwl_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("frame_change_warning_level test failed");
			$finish;
		end
	end

	// Stall the result side for a random count after each accepted word
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			hold_cnt = calm ? 0 : $urandom_range(0, 15);
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Send one pixel word after a random gap and hold it until taken
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blue       <= b;
		green      <= g;
		red        <= r;
		last_pixel <= last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	// Drop valid and wait until every frame result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [15:0] a);
		cfg_data  <= a;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One frame: fresh content, a small drift from the last frame, or a repeat
	task automatic send_frame(input int unsigned len);
		int          mode, d;
		logic [7:0]  b, g, r;
		mode = $urandom_range(0, 9);
		calm = ($urandom_range(0, 4) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
			if (i < fcwl_pkg::STORE_DEPTH && mode >= 3) begin
				d = (mode >= 8) ? 0 : 4;
				b = 8'(last_b[i] + $urandom_range(0, 2 * d) - d);
				g = 8'(last_g[i] + $urandom_range(0, 2 * d) - d);
				r = 8'(last_r[i] + $urandom_range(0, 2 * d) - d);
			end
			if (i < fcwl_pkg::STORE_DEPTH) begin
				last_b[i] = b; last_g[i] = g; last_r[i] = r;
			end
			send_pixel(b, g, r, i == len - 1);
		end
	endtask

	// Random frames, mostly repeating the size so history matches
	task automatic random_phase(input int quota);
		int start;
		start = pixels_sent;
		while (pixels_sent - start < quota) begin
			if ($urandom_range(0, 9) < 3)
				frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 40);
			send_frame(frame_len);
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < fcwl_pkg::STORE_DEPTH; i++) begin
			last_b[i] = '0; last_g[i] = '0; last_r[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extremes with the reset weight
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd170, 8'd85, 8'd170, 1'b1);
		drain();

		// Heaviest weight: alternating black and white frames, each a full change, drive the level to zero
		write_alpha(16'hFFFF);
		for (int k = 0; k < 6; k++)
			send_pixel(8'(k[0] ? 8'hFF : 8'h00), 8'(k[0] ? 8'hFF : 8'h00),
				8'(k[0] ? 8'hFF : 8'h00), 1'b1);
		drain();
		random_phase(360);

		// Lightest weight
		write_alpha(16'd1);
		random_phase(360);

		// Zero weight falls back to the reset weight
		write_alpha(16'd0);
		random_phase(360);

		write_alpha(16'($urandom_range(1, 65535)));
		random_phase(360);

		if (failures == 0)
			$display("frame_change_warning_level test passed");
		else
			$display("frame_change_warning_level test failed");
		$finish;
	end

endmodule
